>>> sv/qtsc_pkg.sv
// Shared constants, types and lamp/green decode functions for the traffic signal controller.
`timescale 1ns / 1ps

package qtsc_pkg;

    localparam int QUEUE_DEPTH     = 8;
    localparam int DIRECTION_COUNT = 5;
    localparam int PTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int DIR_W           = 3;
    localparam int DCNT_W          = 4;
    localparam int LAMP_W          = 11;
    localparam int PHASE_W         = 3;
    localparam int QSIZE_W         = 4;
    localparam int ARR_W           = 2;
    localparam int TICK_W          = 8;
    localparam int HOLD_W          = 4;
    localparam int LIMIT_W         = 4;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    // Register indexes (word address bits).
    localparam logic [1:0] REG_TICKS_PER_STEP = 2'd0;
    localparam logic [1:0] REG_GREEN_HOLD     = 2'd1;
    localparam logic [1:0] REG_DIR_LIMIT      = 2'd2;

    localparam logic [TICK_W-1:0]  TICKS_RESET = 8'd10;
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 4'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;

    // Directions.
    localparam logic [DIR_W-1:0] DIR_NL = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NR = 3'd1;
    localparam logic [DIR_W-1:0] DIR_WL = 3'd2;
    localparam logic [DIR_W-1:0] DIR_WS = 3'd3;
    localparam logic [DIR_W-1:0] DIR_ES = 3'd4;

    // Arrival results.
    localparam logic [ARR_W-1:0] ARR_NONE       = 2'd0;
    localparam logic [ARR_W-1:0] ARR_ADDED      = 2'd1;
    localparam logic [ARR_W-1:0] ARR_DIR_FULL   = 2'd2;
    localparam logic [ARR_W-1:0] ARR_QUEUE_FULL = 2'd3;

    // Signal phases.
    localparam logic [PHASE_W-1:0] PH_S0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_S1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_S2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_S3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_S4 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_S5 = 3'd5;
    localparam logic [PHASE_W-1:0] PH_S6 = 3'd6;
    localparam logic [PHASE_W-1:0] PH_S7 = 3'd7;

    typedef logic [DIR_W-1:0] dir_t;

    // Queue contents as seen after this word's arrival has been applied.
    typedef struct packed {
        logic                                   head_valid;
        dir_t                                   head_dir;
        logic [CNT_W-1:0]                       count;
        logic [DIRECTION_COUNT-1:0][DCNT_W-1:0] dir_counts;
    } queue_view_t;

    // What the controller did on this word.
    typedef struct packed {
        logic step;
        logic passed;
        dir_t pdir;
    } step_info_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [LAMP_W-1:0] phase_lamps(input logic [PHASE_W-1:0] ph);
        case (ph)
            PH_S0:   return 11'h20C;
            PH_S1:   return 11'h20A;
            PH_S2:   return 11'h649;
            PH_S3:   return 11'h209;
            PH_S4:   return 11'h10A;
            PH_S5:   return 11'h0E1;
            PH_S6:   return 11'h091;
            PH_S7:   return 11'h0D1;
            default: return '0;
        endcase
    endfunction

    function automatic logic green_in_phase(input logic [PHASE_W-1:0] ph, input dir_t d);
        case (ph)
            PH_S0:   return (d == DIR_ES) || (d == DIR_WS);
            PH_S2:   return (d == DIR_NL) || (d == DIR_WL) || (d == DIR_WS);
            PH_S3:   return (d == DIR_WS);
            PH_S5:   return (d == DIR_NL) || (d == DIR_NR);
            default: return 1'b0;
        endcase
    endfunction

endpackage

>>> sv/queued_traffic_signal_controller_unit.sv
// Top level of the queued traffic signal controller: ports, registers and word stages.
//
//   Channel  Direction  Ports                                   Word
//   s_       in         s_valid/s_ready                         button_level, arrival_direction
//   m_       out        m_valid/m_ready                         lamps, phase, step, arrival, pass, size
//   APB      in/out     psel/penable/pwrite/paddr/pwdata/...    ticks, hold, direction limit
//
// One word per cycle sustained while m_ready is high. A word is captured in the input
// register, is evaluated there and lands in the output register when it fires.
// When m_ready is low the output register holds and the input register holds its word;
// s_ready drops only while both are full. Synchronous active-low reset, no clearing pass.
`timescale 1ns / 1ps

module queued_traffic_signal_controller_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_button_level,
    input  logic [2:0]                   s_arrival_direction,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [qtsc_pkg::LAMP_W-1:0]  m_lamp_pattern,
    output logic [qtsc_pkg::PHASE_W-1:0] m_phase_now,
    output logic                         m_step_taken,
    output logic [qtsc_pkg::ARR_W-1:0]   m_arrival_result,
    output logic                         m_car_passed,
    output logic [2:0]                   m_passed_direction,
    output logic [qtsc_pkg::QSIZE_W-1:0] m_queue_size,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qtsc_pkg::ADDR_W-1:0]  paddr,
    input  logic [qtsc_pkg::DATA_W-1:0]  pwdata,
    output logic [qtsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import qtsc_pkg::*;

    logic [TICK_W-1:0]  ticks_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_write;

    logic in_valid_reg;
    logic level_reg;
    dir_t dir_reg;
    logic button_last_reg;

    logic               out_valid_reg;
    logic [LAMP_W-1:0]  lamp_reg;
    logic [PHASE_W-1:0] phase_out_reg;
    logic               step_reg;
    logic [ARR_W-1:0]   arrival_reg;
    logic               passed_reg;
    dir_t               pdir_reg;
    logic [QSIZE_W-1:0] qsize_reg;

    logic               fire;
    logic               press;
    logic [ARR_W-1:0]   arrival;
    queue_view_t        view;
    logic [QSIZE_W-1:0] queue_size;
    step_info_t         info;
    logic [LAMP_W-1:0]  lamps;
    logic [PHASE_W-1:0] phase_now;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
            hold_reg  <= HOLD_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_TICKS_PER_STEP: ticks_reg <= pwdata[TICK_W-1:0];
                REG_GREEN_HOLD:     hold_reg  <= pwdata[HOLD_W-1:0];
                REG_DIR_LIMIT:      limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TICKS_PER_STEP: prdata = DATA_W'(ticks_reg);
            REG_GREEN_HOLD:     prdata = DATA_W'(hold_reg);
            REG_DIR_LIMIT:      prdata = DATA_W'(limit_reg);
            default:            prdata = '0;
        endcase
    end

    // The word in the input register is evaluated whenever the output register can take it.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign press   = button_last_reg && !level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            button_last_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                button_last_reg <= level_reg;
            end
            out_valid_reg <= fire || (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            level_reg <= s_button_level;
            dir_reg   <= s_arrival_direction;
        end
        if (fire) begin
            lamp_reg      <= lamps;
            phase_out_reg <= phase_now;
            step_reg      <= info.step;
            arrival_reg   <= arrival;
            passed_reg    <= info.passed;
            pdir_reg      <= info.pdir;
            qsize_reg     <= queue_size;
        end
    end

    qtsc_queue u_queue (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .fire                (fire),
        .press               (press),
        .dir                 (dir_reg),
        .per_direction_limit (limit_reg),
        .pop                 (info.passed),
        .arrival             (arrival),
        .view                (view),
        .queue_size          (queue_size)
    );

    qtsc_phase u_phase (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fire             (fire),
        .ticks_per_step   (ticks_reg),
        .green_hold_steps (hold_reg),
        .view             (view),
        .info             (info),
        .lamps_out        (lamps),
        .phase_out        (phase_now)
    );

    assign m_valid            = out_valid_reg;
    assign m_lamp_pattern     = lamp_reg;
    assign m_phase_now        = phase_out_reg;
    assign m_step_taken       = step_reg;
    assign m_arrival_result   = arrival_reg;
    assign m_car_passed       = passed_reg;
    assign m_passed_direction = pdir_reg;
    assign m_queue_size       = qsize_reg;

endmodule

>>> sv/qtsc_queue.sv
// Car queue: direction FIFO, per-direction counts and arrival admission.
`timescale 1ns / 1ps

module qtsc_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic                         press,
    input  qtsc_pkg::dir_t               dir,
    input  logic [qtsc_pkg::LIMIT_W-1:0] per_direction_limit,
    input  logic                         pop,
    output logic [qtsc_pkg::ARR_W-1:0]   arrival,
    output qtsc_pkg::queue_view_t        view,
    output logic [qtsc_pkg::QSIZE_W-1:0] queue_size
);
    import qtsc_pkg::*;

    dir_t                                   fifo_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]                       head_reg, head_next;
    logic [PTR_W-1:0]                       tail_reg, tail_next;
    logic [CNT_W-1:0]                       count_reg, count_next;
    logic [DIRECTION_COUNT-1:0][DCNT_W-1:0] counts_reg, counts_next;
    dir_t                                   head_dir_reg;

    logic                                   dir_ok;
    logic [DCNT_W-1:0]                      dir_cnt;
    logic                                   enq;
    logic [CNT_W-1:0]                       count_enq;
    logic [DIRECTION_COUNT-1:0][DCNT_W-1:0] counts_enq;
    dir_t                                   head_dir;

    always_comb begin
        dir_ok  = dir < DIR_W'(DIRECTION_COUNT);
        dir_cnt = dir_ok ? counts_reg[dir] : '0;
        enq     = 1'b0;
        arrival = ARR_NONE;
        if (press) begin
            if (!dir_ok || dir_cnt >= DCNT_W'(per_direction_limit)) begin
                arrival = ARR_DIR_FULL;
            end else if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                arrival = ARR_QUEUE_FULL;
            end else begin
                arrival = ARR_ADDED;
                enq     = 1'b1;
            end
        end

        count_enq  = count_reg + CNT_W'(enq);
        counts_enq = counts_reg;
        if (enq) begin
            counts_enq[dir] = counts_reg[dir] + 1'b1;
        end

        // A car queued into an empty FIFO this word is already the head.
        head_dir = (count_reg == '0) ? dir : head_dir_reg;

        view.head_valid = (count_enq != '0);
        view.head_dir   = head_dir;
        view.count      = count_enq;
        view.dir_counts = counts_enq;

        count_next  = count_enq - CNT_W'(pop);
        counts_next = counts_enq;
        if (pop && head_dir < DIR_W'(DIRECTION_COUNT) && counts_enq[head_dir] != '0) begin
            counts_next[head_dir] = counts_enq[head_dir] - 1'b1;
        end
        head_next = pop ? ptr_inc(head_reg) : head_reg;
        tail_next = enq ? ptr_inc(tail_reg) : tail_reg;

        queue_size = QSIZE_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            counts_reg <= '0;
        end else if (fire) begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            counts_reg <= counts_next;
        end
    end

    // The entry at the next head is read ahead, with the direction being written forwarded.
    always_ff @(posedge aclk) begin
        if (fire) begin
            if (enq) begin
                fifo_mem[tail_reg] <= dir;
            end
            head_dir_reg <= (enq && tail_reg == head_next) ? dir : fifo_mem[head_next];
        end
    end

endmodule

>>> sv/qtsc_phase.sv
// Step timer, phase sequencer, green hold counter and lamp latch.
`timescale 1ns / 1ps

module qtsc_phase (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic [qtsc_pkg::TICK_W-1:0]  ticks_per_step,
    input  logic [qtsc_pkg::HOLD_W-1:0]  green_hold_steps,
    input  qtsc_pkg::queue_view_t        view,
    output qtsc_pkg::step_info_t         info,
    output logic [qtsc_pkg::LAMP_W-1:0]  lamps_out,
    output logic [qtsc_pkg::PHASE_W-1:0] phase_out
);
    import qtsc_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LAMP_W-1:0]  lamps_reg, lamps_next;
    logic [TICK_W-1:0]  div_reg, div_next;
    logic [HOLD_W-1:0]  wait_reg, wait_next;

    logic [TICK_W-1:0]                      div_inc;
    logic                                   step;
    logic                                   passed;
    logic [DIRECTION_COUNT-1:0][DCNT_W-1:0] cnt;
    logic [CNT_W-1:0]                       qcount;
    logic                                   nxt_valid;
    logic [PHASE_W-1:0]                     nxt;
    logic [HOLD_W-1:0]                      wait_inc;

    always_comb begin
        div_inc = div_reg + 1'b1;
        step    = (div_inc == ticks_per_step);
        passed  = step && view.head_valid && green_in_phase(phase_reg, view.head_dir);

        // Phase choice looks at the queue after the head car has left.
        cnt    = view.dir_counts;
        qcount = view.count - CNT_W'(passed);
        if (passed && view.head_dir < DIR_W'(DIRECTION_COUNT)
                && view.dir_counts[view.head_dir] != '0) begin
            cnt[view.head_dir] = view.dir_counts[view.head_dir] - 1'b1;
        end

        nxt_valid = 1'b1;
        nxt       = PH_S2;
        case (phase_reg)
            PH_S0: begin
                if (qcount == '0) begin
                    nxt_valid = 1'b0;
                end else if (cnt[DIR_NL] != '0) begin
                    nxt = PH_S4;
                end else if (cnt[DIR_NR] != '0 || cnt[DIR_WL] != '0) begin
                    nxt = PH_S1;
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            PH_S1: nxt = PH_S2;
            PH_S2: nxt = PH_S3;
            PH_S3: nxt = PH_S0;
            PH_S4: nxt = PH_S5;
            PH_S5: begin
                if (qcount == '0) begin
                    nxt_valid = 1'b0;
                end else if (cnt[DIR_WL] != '0) begin
                    nxt = PH_S7;
                end else if (cnt[DIR_WS] != '0 || cnt[DIR_ES] != '0) begin
                    nxt = PH_S6;
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            PH_S6: nxt = PH_S0;
            default: nxt = PH_S2;
        endcase

        wait_inc   = wait_reg + 1'b1;
        phase_next = phase_reg;
        wait_next  = wait_reg;
        lamps_next = lamps_reg;
        div_next   = div_inc;
        if (step) begin
            div_next   = '0;
            lamps_next = phase_lamps(phase_reg);
            if ((phase_reg == PH_S0 || phase_reg == PH_S5) && nxt_valid) begin
                // Green phases hold for a number of steps before moving on.
                wait_next = wait_inc;
                if (wait_inc >= green_hold_steps) begin
                    phase_next = nxt;
                    wait_next  = '0;
                end
            end else begin
                wait_next = '0;
                if (nxt_valid) begin
                    phase_next = nxt;
                end
            end
        end

        info.step   = step;
        info.passed = passed;
        info.pdir   = passed ? view.head_dir : '0;
        lamps_out   = lamps_next;
        phase_out   = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_S0;
            lamps_reg <= '0;
            div_reg   <= '0;
            wait_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            lamps_reg <= lamps_next;
            div_reg   <= div_next;
            wait_reg  <= wait_next;
        end
    end

endmodule
